/* design/top_k_hit_selector_top_macros.svh */
// ----------------------------------------------------------------------------
// Top-k hit selector assertion macros
// Shared concurrent assertion forms for the checker.
// ----------------------------------------------------------------------------
`ifndef TOP_K_HIT_SELECTOR_TOP_MACROS_SVH
`define TOP_K_HIT_SELECTOR_TOP_MACROS_SVH

// same-cycle implication, disabled during reset
`define TKHS_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// next-cycle implication, disabled during reset
`define TKHS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) ante |=> cons) else $error(msg);

`endif

/* design/tkhs_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Top-k hit selector package
// Fixed field widths, register reset value, codes and sequencer types.
// ----------------------------------------------------------------------------
package tkhs_pkg;

  localparam int KIND_W     = 1;
  localparam int SCORE_IN_W = 32;
  localparam int TYPE_W     = 2;
  localparam int ORD_W      = 63;
  localparam int HELD_W     = 6;
  localparam int KEEP_W     = 6;
  localparam int CMP_W      = 8;

  localparam logic [KEEP_W-1:0] KEEP_RESET = 6'd20;

  localparam logic [KIND_W-1:0] KIND_OFFER = 1'b0;
  localparam logic [KIND_W-1:0] KIND_DRAIN = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_APPEND,
    S_SCAN,
    S_DECIDE,
    S_THR,
    S_EMIT_OFFER,
    S_EMIT_EMPTY,
    S_EMIT_HIT
  } tkhs_state_e;

  typedef enum logic [1:0] {
    M_WORST,
    M_MIN,
    M_BEST
  } tkhs_mode_e;

endpackage

/* design/tkhs_store.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Top-k hit selector entry store
// One write port and one registered read port over the held hit entries.
// ----------------------------------------------------------------------------
module tkhs_store #(
  parameter int DEPTH = 32,
  parameter int WIDTH = 97,
  parameter int AW    = 5
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AW-1:0]    wr_addr_i,
  input  logic [WIDTH-1:0] wr_data_i,
  input  logic             rd_en_i,
  input  logic [AW-1:0]    rd_addr_i,
  output logic [WIDTH-1:0] rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

/* design/top_k_hit_selector_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Top-k hit selector
// Keeps the best keep_count hits by score, type and ordinal, reports the
// admission threshold per offer and drains the held hits in rank order.
// ----------------------------------------------------------------------------
// channel | direction | handshake               | payload
// in      | input     | in_valid_i / in_ready_o | kind, offer_score/type/ordinal
// out     | output    | out_valid_o/out_ready_i | accepted .. last
// cfg     | input     | cfg_valid_i/cfg_ready_o | cfg_data_i (keep_count)
//
// One comparator walks the store through its single read port, one entry a
// cycle. A nonzero offer into a full store runs a worst-entry pass, and an
// offer that leaves the store full then runs a minimum-score pass. A drain
// runs one pass per emitted hit. Reset clears the hit count and sets
// keep_count to 20; the store itself needs no clearing pass. A stalled output holds the sequencer.
// ----------------------------------------------------------------------------
module top_k_hit_selector_top
  import tkhs_pkg::*;
#(
  parameter int STORE_DEPTH = 32,
  parameter int SCORE_BITS  = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [KIND_W-1:0]     kind_i,
  input  logic [SCORE_IN_W-1:0] offer_score_i,
  input  logic [TYPE_W-1:0]     offer_type_i,
  input  logic [ORD_W-1:0]      offer_ordinal_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic                  accepted_o,
  output logic [SCORE_IN_W-1:0] threshold_o,
  output logic [HELD_W-1:0]     held_o,
  output logic [SCORE_IN_W-1:0] out_score_o,
  output logic [TYPE_W-1:0]     out_type_o,
  output logic [ORD_W-1:0]      out_ordinal_o,
  output logic                  empty_res_o,
  output logic                  last_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [KEEP_W-1:0]     cfg_data_i
);

  localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int CW = $clog2(STORE_DEPTH + 1);
  localparam int EW = SCORE_BITS + TYPE_W + ORD_W;
  localparam logic [63:0] SCORE_MAX = {64{1'b1}} >> (64 - SCORE_BITS);
  localparam logic [KEEP_W:0] DEPTH_K = (KEEP_W + 1)'(STORE_DEPTH);

  function automatic logic [EW-1:0] key_f(input logic [EW-1:0] e, input logic full);
    logic [EW-1:0] k;
    if (full) begin
      k = {e[EW-1 -: SCORE_BITS], ~e[ORD_W+TYPE_W-1:ORD_W], ~e[ORD_W-1:0]};
    end else begin
      k = {e[EW-1 -: SCORE_BITS], {(TYPE_W + ORD_W){1'b0}}};
    end
    return k;
  endfunction

  function automatic logic [SCORE_IN_W-1:0] score_out_f(input logic [EW-1:0] e);
    logic [63:0] s;
    s = 64'(e[EW-1 -: SCORE_BITS]);
    return s[SCORE_IN_W-1:0];
  endfunction

  tkhs_state_e state_q, state_d;
  tkhs_mode_e  mode_q, mode_d;

  logic [KEEP_W-1:0]      keep_q;
  logic [CW-1:0]          held_q, held_d;
  logic [CW-1:0]          iss_q, iss_d;
  logic [CW-1:0]          emit_q, emit_d;
  logic                   rd_vld_q;
  logic [AW-1:0]          rd_idx_q;
  logic                   have_q, have_d;
  logic                   item_acc_q, item_acc_d;
  logic                   thr_on_q, thr_on_d;
  logic [STORE_DEPTH-1:0] done_q, done_d;
  logic                   out_valid_q, out_valid_d;

  logic [EW-1:0]          off_q, off_d;
  logic [EW-1:0]          acc_ent_q, acc_ent_d;
  logic [AW-1:0]          acc_idx_q, acc_idx_d;

  logic                   out_load;
  logic                   out_acc_q, out_acc_d;
  logic [SCORE_IN_W-1:0]  out_thr_q, out_thr_d;
  logic [HELD_W-1:0]      out_held_q, out_held_d;
  logic [SCORE_IN_W-1:0]  out_score_q, out_score_d;
  logic [TYPE_W-1:0]      out_type_q, out_type_d;
  logic [ORD_W-1:0]       out_ord_q, out_ord_d;
  logic                   out_empty_q, out_empty_d;
  logic                   out_last_q, out_last_d;

  logic                   rd_en;
  logic [EW-1:0]          rd_data;
  logic                   wr_en;
  logic [AW-1:0]          wr_addr;
  logic [EW-1:0]          cmp_a, cmp_b;
  logic                   cmp_gt;
  logic                   upd;
  logic                   scan_done;
  logic                   out_free;
  logic                   hit_last;
  logic [KEEP_W:0]        eff_k;
  logic                   is_full;
  logic [CMP_W-1:0]       held_w;
  logic [63:0]            sc_in, sc_sat;
  logic [EW-1:0]          in_ent;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_free    = !out_valid_q || out_ready_i;

  always_comb begin
    if (keep_q == '0) begin
      eff_k = (KEEP_W + 1)'(1);
    end else if ({1'b0, keep_q} > DEPTH_K) begin
      eff_k = DEPTH_K;
    end else begin
      eff_k = {1'b0, keep_q};
    end
  end

  assign held_w  = CMP_W'(held_q);
  assign is_full = (held_w >= CMP_W'(eff_k)) && (held_q != '0);

  assign sc_in  = 64'(offer_score_i);
  assign sc_sat = (sc_in > SCORE_MAX) ? SCORE_MAX : sc_in;
  assign in_ent = {sc_sat[SCORE_BITS-1:0], offer_type_i, offer_ordinal_i};

  assign rd_en     = (state_q == S_SCAN) && (iss_q < held_q);
  assign scan_done = (state_q == S_SCAN) && (iss_q == held_q) && !rd_vld_q;
  assign hit_last  = ((emit_q + CW'(1)) == held_q);

  always_comb begin
    if (state_q == S_DECIDE) begin
      cmp_a = key_f(off_q, 1'b1);
      cmp_b = key_f(acc_ent_q, 1'b1);
    end else begin
      case (mode_q)
        M_WORST: begin
          cmp_a = key_f(acc_ent_q, 1'b1);
          cmp_b = key_f(rd_data, 1'b1);
        end
        M_MIN: begin
          cmp_a = key_f(acc_ent_q, 1'b0);
          cmp_b = key_f(rd_data, 1'b0);
        end
        M_BEST: begin
          cmp_a = key_f(rd_data, 1'b1);
          cmp_b = key_f(acc_ent_q, 1'b1);
        end
        default: begin
          cmp_a = '0;
          cmp_b = '0;
        end
      endcase
    end
  end

  assign cmp_gt = cmp_a > cmp_b;

  always_comb begin
    if (mode_q == M_BEST) begin
      upd = rd_vld_q && !done_q[rd_idx_q] && (!have_q || cmp_gt);
    end else begin
      upd = rd_vld_q && (!have_q || cmp_gt);
    end
  end

  always_comb begin
    state_d     = state_q;
    mode_d      = mode_q;
    held_d      = held_q;
    iss_d       = rd_en ? iss_q + CW'(1) : iss_q;
    emit_d      = emit_q;
    have_d      = have_q || upd;
    item_acc_d  = item_acc_q;
    thr_on_d    = thr_on_q;
    done_d      = done_q;
    off_d       = off_q;
    acc_ent_d   = upd ? rd_data : acc_ent_q;
    acc_idx_d   = upd ? rd_idx_q : acc_idx_q;
    wr_en       = 1'b0;
    wr_addr     = held_q[AW-1:0];
    out_load    = 1'b0;
    out_acc_d   = 1'b0;
    out_thr_d   = '0;
    out_held_d  = '0;
    out_score_d = '0;
    out_type_d  = '0;
    out_ord_d   = '0;
    out_empty_d = 1'b0;
    out_last_d  = 1'b1;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          off_d      = in_ent;
          item_acc_d = 1'b0;
          if (kind_i == KIND_OFFER) begin
            if (sc_sat == '0) begin
              state_d = S_THR;
            end else if (!is_full && (held_w < CMP_W'(eff_k))) begin
              state_d = S_APPEND;
            end else begin
              mode_d  = M_WORST;
              iss_d   = '0;
              have_d  = 1'b0;
              state_d = S_SCAN;
            end
          end else if (held_q == '0) begin
            state_d = S_EMIT_EMPTY;
          end else begin
            emit_d  = '0;
            mode_d  = M_BEST;
            iss_d   = '0;
            have_d  = 1'b0;
            state_d = S_SCAN;
          end
        end
      end
      S_APPEND: begin
        wr_en      = 1'b1;
        wr_addr    = held_q[AW-1:0];
        held_d     = held_q + CW'(1);
        item_acc_d = 1'b1;
        state_d    = S_THR;
      end
      S_SCAN: begin
        if (scan_done) begin
          case (mode_q)
            M_WORST: state_d = S_DECIDE;
            M_MIN:   state_d = S_EMIT_OFFER;
            M_BEST:  state_d = S_EMIT_HIT;
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_DECIDE: begin
        if (cmp_gt) begin
          wr_en      = 1'b1;
          wr_addr    = acc_idx_q;
          item_acc_d = 1'b1;
        end
        state_d = S_THR;
      end
      S_THR: begin
        thr_on_d = is_full;
        if (is_full) begin
          mode_d  = M_MIN;
          iss_d   = '0;
          have_d  = 1'b0;
          state_d = S_SCAN;
        end else begin
          state_d = S_EMIT_OFFER;
        end
      end
      S_EMIT_OFFER: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_acc_d  = item_acc_q;
          out_thr_d  = thr_on_q ? score_out_f(acc_ent_q) : '0;
          out_held_d = held_w[HELD_W-1:0];
          state_d    = S_IDLE;
        end
      end
      S_EMIT_EMPTY: begin
        if (out_free) begin
          out_load    = 1'b1;
          out_empty_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      S_EMIT_HIT: begin
        if (out_free) begin
          out_load    = 1'b1;
          out_score_d = score_out_f(acc_ent_q);
          out_type_d  = acc_ent_q[ORD_W+TYPE_W-1:ORD_W];
          out_ord_d   = acc_ent_q[ORD_W-1:0];
          out_last_d  = hit_last;
          emit_d      = emit_q + CW'(1);
          if (hit_last) begin
            held_d  = '0;
            done_d  = '0;
            state_d = S_IDLE;
          end else begin
            done_d[acc_idx_q] = 1'b1;
            mode_d  = M_BEST;
            iss_d   = '0;
            have_d  = 1'b0;
            state_d = S_SCAN;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign out_valid_d = out_load | (out_valid_q & ~out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      mode_q      <= M_WORST;
      keep_q      <= KEEP_RESET;
      held_q      <= '0;
      iss_q       <= '0;
      emit_q      <= '0;
      rd_vld_q    <= 1'b0;
      have_q      <= 1'b0;
      item_acc_q  <= 1'b0;
      thr_on_q    <= 1'b0;
      done_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      mode_q      <= mode_d;
      if (cfg_valid_i) begin
        keep_q <= cfg_data_i;
      end
      held_q      <= held_d;
      iss_q       <= iss_d;
      emit_q      <= emit_d;
      rd_vld_q    <= rd_en;
      have_q      <= have_d;
      item_acc_q  <= item_acc_d;
      thr_on_q    <= thr_on_d;
      done_q      <= done_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    off_q     <= off_d;
    acc_ent_q <= acc_ent_d;
    acc_idx_q <= acc_idx_d;
    rd_idx_q  <= iss_q[AW-1:0];
    if (out_load) begin
      out_acc_q   <= out_acc_d;
      out_thr_q   <= out_thr_d;
      out_held_q  <= out_held_d;
      out_score_q <= out_score_d;
      out_type_q  <= out_type_d;
      out_ord_q   <= out_ord_d;
      out_empty_q <= out_empty_d;
      out_last_q  <= out_last_d;
    end
  end

  tkhs_store #(
    .DEPTH (STORE_DEPTH),
    .WIDTH (EW),
    .AW    (AW)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (off_q),
    .rd_en_i   (rd_en),
    .rd_addr_i (iss_q[AW-1:0]),
    .rd_data_o (rd_data)
  );

  assign out_valid_o   = out_valid_q;
  assign accepted_o    = out_acc_q;
  assign threshold_o   = out_thr_q;
  assign held_o        = out_held_q;
  assign out_score_o   = out_score_q;
  assign out_type_o    = out_type_q;
  assign out_ordinal_o = out_ord_q;
  assign empty_res_o   = out_empty_q;
  assign last_o        = out_last_q;

endmodule

/* design/tkhs_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Top-k hit selector port checker
// Watches the top level ports over time; attached by bind.
// ----------------------------------------------------------------------------
`include "top_k_hit_selector_top_macros.svh"

module tkhs_checker
  import tkhs_pkg::*;
(
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_ready_o,
  input logic                  out_valid_o,
  input logic                  out_ready_i,
  input logic                  accepted_o,
  input logic [HELD_W-1:0]     held_o,
  input logic [SCORE_IN_W-1:0] out_score_o,
  input logic [TYPE_W-1:0]     out_type_o,
  input logic                  empty_res_o,
  input logic                  last_o
);

  `TKHS_ASSERT_NEXT(a_busy_after_in, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o, "input taken while busy")

  `TKHS_ASSERT(a_empty_shape, clk_i, rst_ni, out_valid_o && empty_res_o |-> last_o && !accepted_o && held_o == '0 && out_type_o == '0, "bad empty drain result")

  `TKHS_ASSERT(a_accept_shape, clk_i, rst_ni, out_valid_o && accepted_o |-> last_o && !empty_res_o && out_score_o == '0, "bad accepted offer result")

  `TKHS_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(out_score_o) && $stable(last_o), "stalled result changed")

endmodule

bind top_k_hit_selector_top tkhs_checker u_tkhs_checker (.*);
